// ----- rtl/core/work_stealing_deque_scheduler_top_assert.svh -----
// Assertion macros for the work-stealing deque scheduler checker.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef WORK_STEALING_DEQUE_SCHEDULER_TOP_ASSERT_SVH
`define WORK_STEALING_DEQUE_SCHEDULER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WSD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/wsd_pkg.sv -----
// Package for the work-stealing deque scheduler: item types, codes and defaults.
// Used by every module of the block but wsd_ram; depends on nothing.
package wsd_pkg;

  localparam int NUM_CPUS_DEF  = 4;
  localparam int SLOT_BITS_DEF = 4;
  localparam int HANDLE_W      = 32;

  localparam logic REQ_PUSH  = 1'b0;
  localparam logic REQ_FETCH = 1'b1;

  typedef enum logic [2:0] {
    ST_PUSHED = 3'd0,
    ST_FULL   = 3'd1,
    ST_POPPED = 3'd2,
    ST_STOLEN = 3'd3,
    ST_NOWORK = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_RESP
  } sched_state_t;

  typedef struct packed {
    logic                req_type;
    logic [1:0]          cpu_index;
    logic [HANDLE_W-1:0] work_handle;
  } wsd_in_t;

  typedef struct packed {
    status_t             status;
    logic [HANDLE_W-1:0] handle_out;
    logic [1:0]          victim_cpu;
  } wsd_out_t;

  typedef struct packed {
    status_t    status;
    logic       mem_we;
    logic [1:0] victim;
  } wsd_dec_t;

endpackage

// ----- rtl/core/wsd_ram.sv -----
// Generic single-port synchronous RAM with a registered read.
// Stand-alone; no package needed.
module wsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end

endmodule

// ----- rtl/core/wsd_ptr_file.sv -----
// Head and tail pointers of every deque, and the per-request decision logic.
// Depends on wsd_pkg for the item and decision types.
module wsd_ptr_file #(
  parameter int NUM_CPUS  = wsd_pkg::NUM_CPUS_DEF,
  parameter int SLOT_BITS = wsd_pkg::SLOT_BITS_DEF,
  localparam int CPU_BITS = $clog2(NUM_CPUS),
  localparam int ADDR_W   = CPU_BITS + SLOT_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  wsd_pkg::wsd_in_t  in_item,
  output wsd_pkg::wsd_dec_t dec,
  output logic [ADDR_W-1:0] mem_addr
);

  localparam int PTR_W = SLOT_BITS + 1;
  localparam logic [PTR_W-1:0] NSLOTS = PTR_W'(1) << SLOT_BITS;

  logic [PTR_W-1:0]    head_r   [NUM_CPUS];
  logic [PTR_W-1:0]    tail_r   [NUM_CPUS];
  logic [PTR_W-1:0]    head_nxt [NUM_CPUS];
  logic [PTR_W-1:0]    tail_nxt [NUM_CPUS];
  logic [NUM_CPUS-1:0] cand;
  logic [CPU_BITS-1:0] own_idx;
  logic [CPU_BITS-1:0] steal_idx;
  logic                own_valid;
  logic [PTR_W-1:0]    own_head;
  logic [PTR_W-1:0]    own_tail;
  logic [PTR_W-1:0]    own_fill;
  logic [PTR_W-1:0]    own_head_dec;
  logic [PTR_W-1:0]    steal_tail;

  always_comb begin
    own_idx   = CPU_BITS'(in_item.cpu_index);
    own_valid = (32'(in_item.cpu_index) < NUM_CPUS);
    for (int p = 0; p < NUM_CPUS; p++) begin
      cand[p] = (head_r[p] != tail_r[p]) && !(own_valid && (CPU_BITS'(p) == own_idx));
    end
    steal_idx = '0;
    for (int p = NUM_CPUS - 1; p >= 0; p--) begin
      if (cand[p]) begin
        steal_idx = CPU_BITS'(p);
      end
    end
    own_head     = own_valid ? head_r[own_idx] : '0;
    own_tail     = own_valid ? tail_r[own_idx] : '0;
    own_fill     = own_head - own_tail;
    own_head_dec = own_head - PTR_W'(1);
    steal_tail   = tail_r[steal_idx];

    for (int p = 0; p < NUM_CPUS; p++) begin
      head_nxt[p] = head_r[p];
      tail_nxt[p] = tail_r[p];
    end
    dec.status = wsd_pkg::ST_NOWORK;
    dec.mem_we = 1'b0;
    dec.victim = '0;
    mem_addr   = {own_idx, own_head[SLOT_BITS-1:0]};

    if (in_item.req_type == wsd_pkg::REQ_PUSH) begin
      if (!own_valid || (own_fill == NSLOTS)) begin
        dec.status = wsd_pkg::ST_FULL;
      end else begin
        dec.status        = wsd_pkg::ST_PUSHED;
        dec.mem_we        = 1'b1;
        head_nxt[own_idx] = own_head + PTR_W'(1);
      end
    end else if (own_valid && (own_fill != '0)) begin
      dec.status        = wsd_pkg::ST_POPPED;
      dec.victim        = in_item.cpu_index;
      mem_addr          = {own_idx, own_head_dec[SLOT_BITS-1:0]};
      head_nxt[own_idx] = own_head_dec;
    end else if (cand != '0) begin
      dec.status          = wsd_pkg::ST_STOLEN;
      dec.victim          = 2'(steal_idx);
      mem_addr            = {steal_idx, steal_tail[SLOT_BITS-1:0]};
      tail_nxt[steal_idx] = steal_tail + PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NUM_CPUS; p++) begin
        head_r[p] <= '0;
        tail_r[p] <= '0;
      end
    end else if (accept) begin
      for (int p = 0; p < NUM_CPUS; p++) begin
        head_r[p] <= head_nxt[p];
        tail_r[p] <= tail_nxt[p];
      end
    end
  end

endmodule

// ----- rtl/core/work_stealing_deque_scheduler_top.sv -----
// Work-stealing deque scheduler: one bounded ring deque of work handles per processor.
// Needs wsd_pkg, wsd_ram and wsd_ptr_file.
//
// Use: a request is taken on a rising edge with start high and busy low. A push
// stores work_handle at the head of the requester's deque, or reports full. A fetch
// pops the requester's newest handle, else steals the oldest handle of the
// lowest-numbered other non-empty deque, else reports no work.
// Output: out_valid is high for exactly one cycle, the cycle after the request is
// taken, with the result on out_item. busy is high in that cycle, so no new request
// is taken while a result is out; the result waits on the registered read of the
// slot memory. The receiver cannot stall the block; a result not taken is lost.
// Reset clears the state machine and every head and tail pointer, so all deques
// are empty. The slot memory is not cleared; only written slots are ever read.
module work_stealing_deque_scheduler_top #(
  parameter int NUM_CPUS  = wsd_pkg::NUM_CPUS_DEF,
  parameter int SLOT_BITS = wsd_pkg::SLOT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  wsd_pkg::wsd_in_t  in_item,
  output logic              out_valid,
  output wsd_pkg::wsd_out_t out_item
);

  localparam int CPU_BITS = $clog2(NUM_CPUS);
  localparam int ADDR_W   = CPU_BITS + SLOT_BITS;
  localparam int DEPTH    = NUM_CPUS << SLOT_BITS;

  wsd_pkg::sched_state_t state_r;
  wsd_pkg::sched_state_t state_nxt;
  wsd_pkg::wsd_dec_t     dec;
  wsd_pkg::status_t      status_r;
  logic [1:0]            victim_r;
  logic [ADDR_W-1:0]     mem_addr;
  logic [wsd_pkg::HANDLE_W-1:0] rdata;
  logic                  accept;

  assign accept = start && !busy;

  wsd_ptr_file #(
    .NUM_CPUS  (NUM_CPUS),
    .SLOT_BITS (SLOT_BITS)
  ) u_ptr (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_item  (in_item),
    .dec      (dec),
    .mem_addr (mem_addr)
  );

  wsd_ram #(
    .WIDTH (wsd_pkg::HANDLE_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (accept && dec.mem_we),
    .addr  (mem_addr),
    .wdata (in_item.work_handle),
    .rdata (rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wsd_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = wsd_pkg::S_RESP;
        end
      end
      wsd_pkg::S_RESP: begin
        state_nxt = wsd_pkg::S_IDLE;
      end
      default: state_nxt = wsd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy      = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      wsd_pkg::S_IDLE: begin
        busy = 1'b0;
      end
      wsd_pkg::S_RESP: begin
        busy      = 1'b1;
        out_valid = 1'b1;
      end
      default: busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wsd_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= dec.status;
      victim_r <= dec.victim;
    end
  end

  always_comb begin
    out_item.status     = status_r;
    out_item.victim_cpu = victim_r;
    if ((status_r == wsd_pkg::ST_POPPED) || (status_r == wsd_pkg::ST_STOLEN)) begin
      out_item.handle_out = rdata;
    end else begin
      out_item.handle_out = '0;
    end
  end

endmodule

// ----- rtl/core/wsd_checker.sv -----
// Port-level checker for the work-stealing deque scheduler, bound to its top level.
// Needs wsd_pkg and the macros of work_stealing_deque_scheduler_top_assert.svh.
`include "work_stealing_deque_scheduler_top_assert.svh"

module wsd_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input wsd_pkg::wsd_in_t  in_item,
  input logic              out_valid,
  input wsd_pkg::wsd_out_t out_item
);

  logic       empty_case;
  logic       fields_zero;
  logic       pop_case;
  logic [1:0] pop_cpu;
  logic [1:0] req_cpu;

  assign empty_case  = out_valid && ((out_item.status == wsd_pkg::ST_PUSHED) ||
                       (out_item.status == wsd_pkg::ST_FULL) ||
                       (out_item.status == wsd_pkg::ST_NOWORK));
  assign fields_zero = (out_item.handle_out == '0) && (out_item.victim_cpu == '0);
  assign pop_case    = out_valid && (out_item.status == wsd_pkg::ST_POPPED);
  assign pop_cpu     = out_item.victim_cpu;
  assign req_cpu     = in_item.cpu_index;

  `WSD_ASSERT_NEXT(a_result_follows, start && !busy, out_valid, "no result after an item")
  `WSD_ASSERT_NOW(a_result_has_item, out_valid, $past(start && !busy), "result without an item")
  `WSD_ASSERT_NEXT(a_single_result, out_valid, !out_valid, "item gave more than one result")
  `WSD_ASSERT_NOW(a_empty_fields, empty_case, fields_zero, "fields not zero")
  `WSD_ASSERT_NOW(a_pop_own, pop_case, pop_cpu == $past(req_cpu), "pop names another processor")

endmodule

bind work_stealing_deque_scheduler_top wsd_checker u_wsd_checker (.*);

// ----- verif/tb_top.sv -----
// Self-checking testbench for work_stealing_deque_scheduler_top: push, pop and steal
// requests are checked against a behavioural model of the per-processor deques.
// Depends on wsd_pkg and the scheduler RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wsd_pkg::*;

  localparam int CPUS   = NUM_CPUS_DEF;
  localparam int SB     = SLOT_BITS_DEF;
  localparam int DEPTH  = 1 << SB;
  localparam int RANDOM_ITEMS = 430;
  localparam int CYCLE_LIMIT  = 200000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  wsd_in_t  in_item = '0;
  logic     busy;
  logic     out_valid;
  wsd_out_t out_item;

  wsd_in_t  request_q[$];
  wsd_out_t reply_q[$];
  int       error_count = 0;
  int       cycle_count = 0;
  int       burst_left = 1;
  int       gap_left = 0;

  logic [HANDLE_W-1:0] slot_mem[CPUS][DEPTH];
  logic [SB:0]         head_ptr[CPUS];
  logic [SB:0]         tail_ptr[CPUS];

  work_stealing_deque_scheduler_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [SB:0] deque_fill(input int p);
    return head_ptr[p] - tail_ptr[p];
  endfunction

  function automatic wsd_out_t schedule_request(input wsd_in_t req);
    wsd_out_t rsp;
    int       cpu;
    logic     found;
    rsp.status     = ST_NOWORK;
    rsp.handle_out = '0;
    rsp.victim_cpu = '0;
    cpu   = req.cpu_index;
    found = 1'b0;
    if (req.req_type == REQ_PUSH) begin
      if (cpu >= CPUS || deque_fill(cpu) == DEPTH) begin
        rsp.status = ST_FULL;
      end else begin
        slot_mem[cpu][head_ptr[cpu][SB-1:0]] = req.work_handle;
        head_ptr[cpu] = head_ptr[cpu] + 1'b1;
        rsp.status = ST_PUSHED;
      end
    end else if (cpu < CPUS && deque_fill(cpu) != 0) begin
      head_ptr[cpu]  = head_ptr[cpu] - 1'b1;
      rsp.handle_out = slot_mem[cpu][head_ptr[cpu][SB-1:0]];
      rsp.victim_cpu = cpu[1:0];
      rsp.status     = ST_POPPED;
    end else begin
      for (int p = 0; p < CPUS; p++) begin
        if (!found && p != cpu && deque_fill(p) != 0) begin
          rsp.handle_out = slot_mem[p][tail_ptr[p][SB-1:0]];
          tail_ptr[p]    = tail_ptr[p] + 1'b1;
          rsp.victim_cpu = p[1:0];
          rsp.status     = ST_STOLEN;
          found          = 1'b1;
        end
      end
    end
    return rsp;
  endfunction

  function automatic void queue_request(input logic rt, input logic [1:0] cpu,
                                        input logic [HANDLE_W-1:0] handle);
    wsd_in_t req;
    req.req_type    = rt;
    req.cpu_index   = cpu;
    req.work_handle = handle;
    request_q.push_back(req);
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("work_stealing_deque_scheduler_top regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        reply_q.push_back(schedule_request(in_item));
        void'(request_q.pop_front());
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start    <= 1'b0;
        end else if (request_q.size() > 0) begin
          start   <= 1'b1;
          in_item <= request_q[0];
          if (burst_left <= 1) begin
            if ($urandom_range(0, 3) == 0) begin
              burst_left <= $urandom_range(40, 80);
              gap_left   <= 0;
            end else begin
              burst_left <= $urandom_range(1, 8);
              gap_left   <= $urandom_range(1, 5);
            end
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    wsd_out_t want;
    if (rst_n && out_valid) begin
      if (reply_q.size() == 0) begin
        $display("%0t: unexpected result status=%0d handle=%h victim=%0d", $time,
                 out_item.status, out_item.handle_out, out_item.victim_cpu);
        error_count++;
      end else begin
        want = reply_q.pop_front();
        if (out_item.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   out_item.status);
          error_count++;
        end
        if (out_item.handle_out !== want.handle_out) begin
          $display("%0t: handle_out expected %h actual %h", $time, want.handle_out,
                   out_item.handle_out);
          error_count++;
        end
        if (out_item.victim_cpu !== want.victim_cpu) begin
          $display("%0t: victim_cpu expected %0d actual %0d", $time, want.victim_cpu,
                   out_item.victim_cpu);
          error_count++;
        end
      end
    end
  end

  initial begin
    int         n;
    int         phase_len;
    int         push_pct;
    logic [1:0] focus;
    logic [1:0] cpu;
    for (int p = 0; p < CPUS; p++) begin
      head_ptr[p] = '0;
      tail_ptr[p] = '0;
    end

    // Empty scheduler, a full deque, LIFO pops and steals from the lowest victim.
    queue_request(REQ_FETCH, 2'd2, 32'hFFFF_FFFF);
    queue_request(REQ_PUSH, 2'd0, 32'h0000_0000);
    queue_request(REQ_PUSH, 2'd0, 32'hFFFF_FFFF);
    for (int i = 2; i < DEPTH; i++) begin
      queue_request(REQ_PUSH, 2'd0, (i % 2) ? 32'h5555_5555 ^ i : 32'hAAAA_AAAA ^ i);
    end
    queue_request(REQ_PUSH, 2'd0, 32'h1234_5678);
    queue_request(REQ_FETCH, 2'd0, 32'h0);
    queue_request(REQ_FETCH, 2'd3, 32'h0);
    queue_request(REQ_PUSH, 2'd2, 32'hAAAA_AAAA);
    queue_request(REQ_FETCH, 2'd1, 32'hFFFF_FFFF);
    queue_request(REQ_PUSH, 2'd3, 32'h8000_0001);
    queue_request(REQ_FETCH, 2'd3, 32'h0);

    n = 0;
    while (n < RANDOM_ITEMS) begin
      phase_len = $urandom_range(8, 40);
      focus     = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 2))
        0:       push_pct = 85;
        1:       push_pct = 50;
        default: push_pct = 15;
      endcase
      for (int k = 0; k < phase_len; k++) begin
        cpu = ($urandom_range(0, 99) < 60) ? focus : 2'($urandom_range(0, 3));
        queue_request(($urandom_range(0, 99) < push_pct) ? REQ_PUSH : REQ_FETCH, cpu,
                      $urandom());
        n++;
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    while (request_q.size() != 0 || reply_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("work_stealing_deque_scheduler_top regression: pass");
    end else begin
      $display("work_stealing_deque_scheduler_top regression: fail");
    end
    $finish;
  end

endmodule
